@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define TRQ_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timed release queue: check failed");

// next-cycle implication, off while reset is high
`define TRQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timed release queue: check failed");

// what must hold in the cycle after a reset cycle
`define TRQ_ASSERT_RESET_NEXT(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("timed release queue: reset check failed");

`endif

@@ sv/trq_pkg.sv @@
// ----------------------------------------------------------------------------
// trq_pkg
// Types, codes and defaults shared by the timed release task queue.
// ----------------------------------------------------------------------------
`default_nettype none

package trq_pkg;

   localparam int TRQ_DEPTH = 16;

   // request op codes
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_WIPE   = 2'd2;

   // result kinds
   localparam logic KIND_RELEASE = 1'b0;
   localparam logic KIND_DROP    = 1'b1;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] event_time;
      logic [15:0] queue_id;
      logic [31:0] surf_handle;
      logic [15:0] clip_w;
      logic [15:0] clip_h;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] task_queue;
      logic [31:0] task_surface;
      logic [15:0] task_clip_w;
      logic [15:0] task_clip_h;
      logic        last;
   } rsp_type;

   // one held task; clip is height in 31..16, width in 15..0
   typedef struct packed {
      logic        valid;
      logic [63:0] time_ns;
      logic [15:0] queue;
      logic [31:0] surface;
      logic [31:0] clip;
   } entry_type;

   localparam entry_type EMPTY_ENTRY = '0;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_WIPE,
      CELL_COMPACT,
      CELL_SHIFT
   } cell_cmd_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      cell_cmd_type cmd;
      logic         phase;
      logic [63:0]  key_time;
      logic [15:0]  key_queue;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ sv/trq_cell.sv @@
// ----------------------------------------------------------------------------
// trq_cell
// One slot of the sorted chain: holds a task and trades it with neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module trq_cell import trq_pkg::*; #(
   parameter bit FIRST = 1'b0,
   parameter bit LAST  = 1'b0,
   parameter bit ODD   = 1'b0
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     new_entry,
   input  entry_type     prev_entry,
   input  entry_type     next_entry,
   input  logic          prev_due,
   output entry_type     entry,
   output logic          due
);

   entry_type entry_ff;
   entry_type entry_in;

   assign entry = entry_ff;
   assign due   = entry_ff.valid && (entry_ff.time_ns <= ctrl.key_time);

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.cmd)
         CELL_HOLD: begin
         end
         CELL_INSERT: begin
            // tasks at or before the new time stay; the rest move up one
            if (!due) begin
               if (FIRST || prev_due) begin
                  entry_in = new_entry;
               end else begin
                  entry_in = prev_entry;
               end
            end
         end
         CELL_WIPE: begin
            if (entry_ff.valid && (entry_ff.queue == ctrl.key_queue)) begin
               entry_in.valid = 1'b0;
            end
         end
         CELL_COMPACT: begin
            // odd/even pairing: a hole swaps with the live task to its right
            if (ODD == ctrl.phase) begin
               if (!LAST && !entry_ff.valid && next_entry.valid) begin
                  entry_in = next_entry;
               end
            end else begin
               if (!FIRST && !prev_entry.valid && entry_ff.valid) begin
                  entry_in.valid = 1'b0;
               end
            end
         end
         CELL_SHIFT: begin
            entry_in = next_entry;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/timed_release_task_queue_core.sv @@
// ----------------------------------------------------------------------------
// timed_release_task_queue_core
// Chain of DEPTH cells holding display tasks sorted by release time.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_valid/req_stall/req_payload; results leave on
//   rsp_valid/rsp_stall/rsp_payload. A request is taken only while the
//   sequencer is idle, so req_stall is high from the cycle after acceptance
//   until the request is finished.
//   Insert: taken, then one shift of the chain. If the chain is
//   full, one drop result is produced instead, with last set.
//   Wipe: tasks of the given queue are cleared, then the odd/even compaction
//   of the chain runs until no hole is left; no result.
//   Tick: released tasks leave one by one from the head cell, oldest time
//   first, last set on the final one; no result if none is due.
//   Results sit in one output register: a stalled result holds, and a tick
//   or a dropped insert waits while a stalled result is in it. A new
//   request is accepted even when the previous one's final result waits.
//   Reset empties the chain and the output register; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_release_task_queue_core import trq_pkg::*; #(
   parameter int DEPTH = TRQ_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_COMPACT,
      ST_DRAIN
   } state_type;

   state_type     state_ff,     state_in;
   req_type       op_ff,        op_in;
   logic          phase_ff,     phase_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff,       rsp_in;

   cell_ctrl_type ctrl;
   cell_cmd_type  cmd;
   entry_type     new_entry;
   entry_type     cell_entry [DEPTH];
   logic [DEPTH-1:0] cell_due;
   logic          hole;
   logic          full;
   logic          out_free;

   assign new_entry = '{valid:   1'b1,
                        time_ns: op_ff.event_time,
                        queue:   op_ff.queue_id,
                        surface: op_ff.surf_handle,
                        clip:    {op_ff.clip_h, op_ff.clip_w}};

   assign ctrl = '{cmd:       cmd,
                   phase:     phase_ff,
                   key_time:  op_ff.event_time,
                   key_queue: op_ff.queue_id};

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      entry_type prev_e;
      entry_type next_e;
      logic      prev_d;

      if (g == 0) begin : g_head
         assign prev_e = EMPTY_ENTRY;
         assign prev_d = 1'b0;
      end else begin : g_body
         assign prev_e = cell_entry[g-1];
         assign prev_d = cell_due[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign next_e = EMPTY_ENTRY;
      end else begin : g_inner
         assign next_e = cell_entry[g+1];
      end

      trq_cell #(
         .FIRST (g == 0),
         .LAST  (g == DEPTH - 1),
         .ODD   (g % 2 == 1)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_entry  (new_entry),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .prev_due   (prev_d),
         .entry      (cell_entry[g]),
         .due        (cell_due[g])
      );
   end

   // an empty slot followed by a held one means compaction is not done
   always_comb begin
      hole = 1'b0;
      for (int i = 0; i < DEPTH - 1; i++) begin
         hole = hole | (!cell_entry[i].valid && cell_entry[i+1].valid);
      end
   end

   assign full     = cell_entry[DEPTH-1].valid;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      phase_in     = phase_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = CELL_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_payload;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (op_ff.op)
               OP_INSERT: begin
                  if (!full) begin
                     cmd      = CELL_INSERT;
                     state_in = ST_IDLE;
                  end else if (out_free) begin
                     rsp_in = '{kind:         KIND_DROP,
                                task_queue:   op_ff.queue_id,
                                task_surface: op_ff.surf_handle,
                                task_clip_w:  op_ff.clip_w,
                                task_clip_h:  op_ff.clip_h,
                                last:         1'b1};
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               OP_WIPE: begin
                  cmd      = CELL_WIPE;
                  phase_in = 1'b0;
                  state_in = ST_COMPACT;
               end
               OP_TICK: begin
                  state_in = ST_DRAIN;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_COMPACT: begin
            if (!hole) begin
               state_in = ST_IDLE;
            end else begin
               cmd      = CELL_COMPACT;
               phase_in = !phase_ff;
            end
         end
         ST_DRAIN: begin
            if (!cell_due[0]) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_in = '{kind:         KIND_RELEASE,
                          task_queue:   cell_entry[0].queue,
                          task_surface: cell_entry[0].surface,
                          task_clip_w:  cell_entry[0].clip[15:0],
                          task_clip_h:  cell_entry[0].clip[31:16],
                          last:         !cell_due[1]};
               rsp_valid_in = 1'b1;
               cmd          = CELL_SHIFT;
               if (!cell_due[1]) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

@@ sv/trq_checker.sv @@
// ----------------------------------------------------------------------------
// trq_checker
// Port-level checks on the timed release task queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module trq_checker import trq_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_payload,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_payload
);

   // a stalled result stays put
   `TRQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // the queue works on one request at a time
   `TRQ_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // a dropped insert is always the only and final result of its request
   `TRQ_ASSERT_IMPL(a_drop_is_last, rsp_valid && (rsp_payload.kind == KIND_DROP),
                    rsp_payload.last)

   // out of reset: idle, nothing pending
   `TRQ_ASSERT_RESET_NEXT(a_reset_idle, !rsp_valid && !req_stall)

endmodule

bind timed_release_task_queue_core trq_checker u_trq_checker (.*);

`default_nettype wire
